[hw/rtl/pcrmv_pkg.sv]
// ----------------------------------------------------------------------------
// pcrmv_pkg
// Shared types and constants for the per-channel running mean/variance block.
// ----------------------------------------------------------------------------
package pcrmv_pkg;

	localparam int unsigned COUNT_W  = 24;
	localparam int unsigned MEAN_W   = 26;
	localparam int unsigned SPREAD_W = 60;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned LINK_W   = 4;
	localparam int unsigned CHIP_W   = 6;
	localparam int unsigned CHAN_W   = 6;
	localparam int unsigned SMP_W    = 10;

	// fixed-point format: the mean is SAMPLE_BITS.FRACTION_BITS, MEAN_W wide
	localparam int unsigned SAMPLE_BITS   = 10;
	localparam int unsigned FRACTION_BITS = 16;

	localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
	localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD,
		ST_DECIDE,
		ST_DIV,
		ST_MEAN,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} state_t;

	// divider handshake
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

[hw/rtl/pcrmv_div.sv]
// ----------------------------------------------------------------------------
// pcrmv_div
// Restoring divider, one quotient bit per cycle, quotient truncated.
// ----------------------------------------------------------------------------
module pcrmv_div import pcrmv_pkg::*; #(
	parameter int unsigned NUM_W = 26,
	parameter int unsigned DEN_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_sts_t         sts,
	output logic [NUM_W-1:0] quo
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   shifted;

	// shift in the next numerator bit and try to subtract
	always_comb begin
		shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		trial   = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DEN_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

[hw/rtl/per_channel_running_mean_variance.sv]
// ----------------------------------------------------------------------------
// per_channel_running_mean_variance
// Per-channel pedestal statistics (Welford update) held in on-chip memory.
// ----------------------------------------------------------------------------
// One item is handled at a time. A read passes through ST_RD, ST_DECIDE and
// ST_DONE; an item with a bad address or the unused code goes straight to
// ST_DONE. An accumulate on an unsaturated entry waits on the bit-serial
// divider that forms the mean step (one quotient bit per cycle over the 26-bit
// mean width). A clear item, and reset, sweep the store one entry per cycle,
// over LINKS*CHIPS_PER_LINK*CHANNELS_PER_CHIP entries (65536 at the defaults);
// no item is taken during the sweep after reset. The result register frees
// the block for the next item once the result has been taken.
module per_channel_running_mean_variance import pcrmv_pkg::*; #(
	parameter int unsigned LINKS             = 16,
	parameter int unsigned CHIPS_PER_LINK    = 64,
	parameter int unsigned CHANNELS_PER_CHIP = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [LINK_W-1:0]   link_id,
	input  logic [CHIP_W-1:0]   chip_id,
	input  logic [CHAN_W-1:0]   channel_id,
	input  logic [SMP_W-1:0]    sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                status,
	output logic [COUNT_W-1:0]  entries,
	output logic [MEAN_W-1:0]   mean,
	output logic [SPREAD_W-1:0] deviation_sum
);

	localparam int unsigned DEPTH  = LINKS * CHIPS_PER_LINK * CHANNELS_PER_CHIP;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned ENT_W  = COUNT_W + MEAN_W + SPREAD_W;
	localparam int unsigned DW     = SAMPLE_BITS + FRACTION_BITS;
	localparam int unsigned PW     = 2 * DW;
	localparam int unsigned IW     = PW - FRACTION_BITS;

	// ---- storage: one entry per channel
	logic [ENT_W-1:0]  mem [DEPTH];
	logic [ENT_W-1:0]  rd_data_s1;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic [ADDR_W-1:0] rd_addr;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
	end

	// ---- control state
	state_t            state_q, state_d;
	logic [ADDR_W:0]   sweep_q;
	logic [ADDR_W-1:0] addr_q;
	logic [OP_W-1:0]   op_q;
	logic              bad_q;
	logic [DW-1:0]     sfix_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [SPREAD_W-1:0] spr_q;
	logic              up_q;
	logic [DW-1:0]     d0_q;
	logic [DW-1:0]     d1_q;
	logic [DW-1:0]     newmean_q;
	logic [PW-1:0]     prod_q;
	logic              ovalid_q;
	logic              ostat_q;
	logic [COUNT_W-1:0]  ocnt_q;
	logic [MEAN_W-1:0]   omean_q;
	logic [SPREAD_W-1:0] ospr_q;

	// address decode of the incoming item
	logic              in_bad;
	logic [31:0]       idx_full;
	always_comb begin
		in_bad = (32'(link_id) >= LINKS) || (32'(chip_id) >= CHIPS_PER_LINK) ||
			(32'(channel_id) >= CHANNELS_PER_CHIP) || (operation != OP_ACC &&
			operation != OP_READ);
		idx_full = (32'(link_id) * CHIPS_PER_LINK + 32'(chip_id)) *
			CHANNELS_PER_CHIP + 32'(channel_id);
	end

	// ---- entry fields from memory
	logic [COUNT_W-1:0]  rd_cnt;
	logic [MEAN_W-1:0]   rd_mean;
	logic [SPREAD_W-1:0] rd_spr;
	logic [DW-1:0]       rd_mean_dw;
	assign {rd_cnt, rd_mean, rd_spr} = rd_data_s1;
	assign rd_mean_dw = DW'(rd_mean);

	// ---- divider for the mean step, fed straight from the read entry
	div_ctl_t            dctl;
	div_sts_t            dsts;
	logic [DW-1:0]       quo;
	logic [COUNT_W:0]    n_ext;
	logic [DW-1:0]       d0_rd;
	logic [COUNT_W:0]    n_rd;

	assign n_ext = {1'b0, cnt_q} + 1'b1;
	assign n_rd  = {1'b0, rd_cnt} + 1'b1;
	assign d0_rd = (sfix_q >= rd_mean_dw) ? sfix_q - rd_mean_dw : rd_mean_dw - sfix_q;

	pcrmv_div #(.NUM_W(DW), .DEN_W(COUNT_W + 1)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.num    (d0_rd),
		.den    (n_rd),
		.sts    (dsts),
		.quo    (quo)
	);

	logic [IW:0]         inc;
	logic [SPREAD_W:0]   sum_ext;
	logic [SPREAD_W-1:0] spr_new;
	assign inc     = {1'b0, prod_q[PW-1:FRACTION_BITS]};
	assign sum_ext = {1'b0, spr_q} + (SPREAD_W+1)'(inc);
	assign spr_new = sum_ext[SPREAD_W] ? SPREAD_MAX : sum_ext[SPREAD_W-1:0];

	// ---- next state
	always_comb begin
		state_d    = state_q;
		dctl.start = 1'b0;
		in_ready   = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = addr_q;
		wr_data    = {cnt_q, mean_q, spr_q};
		rd_addr    = addr_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !ovalid_q;
				rd_addr  = ADDR_W'(idx_full);
				if (in_valid && in_ready) begin
					if (operation == OP_CLEAR) state_d = ST_CLEAR;
					else if (in_bad) state_d = ST_DONE;
					else state_d = ST_RD;
				end
			end
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q[ADDR_W-1:0];
				wr_data = '0;
				if (sweep_q == (ADDR_W+1)'(DEPTH - 1)) state_d = ST_DONE;
			end
			ST_RD: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (op_q == OP_READ || rd_cnt == COUNT_MAX) state_d = ST_DONE;
				else begin
					dctl.start = 1'b1;
					state_d    = ST_DIV;
				end
			end
			ST_DIV: if (dsts.done) state_d = ST_MEAN;
			ST_MEAN: state_d = ST_MUL;
			ST_MUL: state_d = ST_SUM;
			ST_SUM: begin
				wr_en   = 1'b1;
				wr_data = {cnt_q, mean_q, spr_new};
				state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			sweep_q  <= '0;
			ovalid_q <= 1'b0;
			op_q     <= OP_CLEAR;
			bad_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				op_q  <= operation;
				bad_q <= (operation == OP_CLEAR) ? 1'b1 : in_bad;
			end
			if (state_q == ST_CLEAR) sweep_q <= sweep_q + 1'b1;
			else sweep_q <= '0;
			if (out_valid && out_ready) ovalid_q <= 1'b0;
			else if (state_q == ST_DONE && op_q != OP_CLEAR) ovalid_q <= 1'b1;
			else if (state_q == ST_DONE && op_q == OP_CLEAR && bad_q) ovalid_q <= 1'b1;
		end
	end

	// ---- datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				addr_q <= ADDR_W'(idx_full);
				sfix_q <= {sample[SAMPLE_BITS-1:0], FRACTION_BITS'(0)};
			end
			ST_DECIDE: begin
				cnt_q  <= rd_cnt;
				mean_q <= rd_mean;
				spr_q  <= rd_spr;
				up_q   <= sfix_q >= rd_mean_dw;
				d0_q   <= d0_rd;
			end
			ST_MEAN: begin
				newmean_q <= up_q ? DW'(mean_q) + quo : DW'(mean_q) - quo;
				d1_q      <= d0_q - quo;
			end
			ST_MUL: begin
				prod_q <= PW'(d0_q) * PW'(d1_q);
				mean_q <= MEAN_W'(newmean_q);
				cnt_q  <= n_ext[COUNT_W-1:0];
			end
			ST_SUM: spr_q <= spr_new;
			default: ;
		endcase
	end

	// the decide stage compares against the freshly read count
	logic [COUNT_W-1:0] dec_cnt;
	assign dec_cnt = rd_cnt;

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			ostat_q <= (op_q == OP_ACC) && (dec_cnt == COUNT_MAX);
			ocnt_q  <= rd_cnt;
			omean_q <= rd_mean;
			ospr_q  <= rd_spr;
		end else if (state_q == ST_SUM) begin
			ostat_q <= 1'b0;
			ocnt_q  <= cnt_q;
			omean_q <= mean_q;
			ospr_q  <= spr_new;
		end else if (state_q == ST_IDLE && !ovalid_q) begin
			ostat_q <= 1'b0;
			ocnt_q  <= '0;
			omean_q <= '0;
			ospr_q  <= '0;
		end
	end

	assign out_valid     = ovalid_q;
	assign status        = ostat_q;
	assign entries       = ocnt_q;
	assign mean          = omean_q;
	assign deviation_sum = ospr_q;

endmodule

[tb/per_channel_running_mean_variance_tb.sv]
// ----------------------------------------------------------------------------
// per_channel_running_mean_variance_tb
// Self-checking bench for the per-channel pedestal statistics block.
// ----------------------------------------------------------------------------
// A queue-fed driver offers operations on the input channel. An in-bench
// Welford predictor computes each expected result when the item is taken.
// A monitor compares every result item with the oldest prediction. Random
// idling on both sides and one long receiver hold-off exercise back-pressure.
// ----------------------------------------------------------------------------
module per_channel_running_mean_variance_tb;
	import pcrmv_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned FRAC = 16;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [LINK_W-1:0] link;
		logic [CHIP_W-1:0] chip;
		logic [CHAN_W-1:0] chan;
		logic [SMP_W-1:0]  smp;
	} stat_op_t;

	typedef struct {
		logic                status;
		logic [COUNT_W-1:0]  count;
		logic [MEAN_W-1:0]   avg;
		logic [SPREAD_W-1:0] spread;
	} stat_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] operation = '0;
	logic [LINK_W-1:0] link_id = '0;
	logic [CHIP_W-1:0] chip_id = '0;
	logic [CHAN_W-1:0] channel_id = '0;
	logic [SMP_W-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic [COUNT_W-1:0] entries;
	logic [MEAN_W-1:0] mean;
	logic [SPREAD_W-1:0] deviation_sum;

	stat_op_t  pending_ops[$];
	stat_res_t expected_stats[$];

	// predictor copy of the channel store, absent entries read as zero
	logic [COUNT_W-1:0]  cnt_tab[int];
	logic [MEAN_W-1:0]   avg_tab[int];
	logic [SPREAD_W-1:0] spr_tab[int];

	int unsigned tx_idle_pct = 23;
	int unsigned rx_idle_pct = 50;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int unsigned hold_left = 0;

	logic [CHAN_W-1:0] hot_chan[8];
	logic [CHIP_W-1:0] hot_chip[8];
	logic [LINK_W-1:0] hot_link[8];
	logic [SMP_W-1:0]  hot_ped[8];

	per_channel_running_mean_variance dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .link_id(link_id), .chip_id(chip_id),
		.channel_id(channel_id), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .entries(entries), .mean(mean),
		.deviation_sum(deviation_sum)
	);

	always #5 clk = ~clk;

	// Welford step on the predictor store
	function automatic stat_res_t predict_stats(stat_op_t it);
		stat_res_t r;
		int key;
		logic [63:0] n, sfix, p0, p, d0, d1, q, inc, m;
		logic up;
		r = '{1'b0, '0, '0, '0};
		key = {it.link, it.chip, it.chan};
		if (it.op == OP_CLEAR) begin
			cnt_tab.delete();
			avg_tab.delete();
			spr_tab.delete();
			return r;
		end
		if (it.op == OP_UNUSED) return r;
		r.count  = cnt_tab.exists(key) ? cnt_tab[key] : '0;
		r.avg    = avg_tab.exists(key) ? avg_tab[key] : '0;
		r.spread = spr_tab.exists(key) ? spr_tab[key] : '0;
		if (it.op == OP_READ) return r;
		if (r.count == COUNT_MAX) begin
			r.status = 1'b1;
			return r;
		end
		n = 64'(r.count) + 64'd1;
		sfix = 64'(it.smp) << FRAC;
		p0 = 64'(r.avg);
		up = (sfix >= p0);
		d0 = up ? sfix - p0 : p0 - sfix;
		q = d0 / n;
		p = up ? p0 + q : p0 - q;
		d1 = up ? sfix - p : p - sfix;
		inc = (d0 * d1) >> FRAC;
		m = 64'(r.spread);
		m = (inc > 64'(SPREAD_MAX) - m) ? 64'(SPREAD_MAX) : m + inc;
		r.count = n[COUNT_W-1:0];
		r.avg = p[MEAN_W-1:0];
		r.spread = m[SPREAD_W-1:0];
		cnt_tab[key] = r.count;
		avg_tab[key] = r.avg;
		spr_tab[key] = r.spread;
		return r;
	endfunction

	// driver: hold the item until taken, then maybe offer the next
	always @(posedge clk) begin
		stat_op_t nxt;
		logic offer;
		offer = in_valid;
		if (in_valid && in_ready) begin
			expected_stats.push_back(predict_stats('{operation, link_id, chip_id,
				channel_id, sample}));
			offer = 1'b0;
		end
		if (!offer && pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
			nxt = pending_ops.pop_front();
			operation <= nxt.op;
			link_id <= nxt.link;
			chip_id <= nxt.chip;
			channel_id <= nxt.chan;
			sample <= nxt.smp;
			offer = 1'b1;
		end
		in_valid <= offer;
	end

	// one long receiver stall
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: compare each result item with the oldest prediction
	always @(posedge clk) begin
		stat_res_t e;
		if (out_valid && out_ready) begin
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result item st=%0d n=%0d m=%0h s=%0h", $time,
					status, entries, mean, deviation_sum);
				errors++;
			end else begin
				e = expected_stats.pop_front();
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					errors++;
				end
				if (entries !== e.count) begin
					$display("%0t: entries exp %0d got %0d", $time, e.count, entries);
					errors++;
				end
				if (mean !== e.avg) begin
					$display("%0t: mean exp %0h got %0h", $time, e.avg, mean);
					errors++;
				end
				if (deviation_sum !== e.spread) begin
					$display("%0t: deviation_sum exp %0h got %0h", $time, e.spread,
						deviation_sum);
					errors++;
				end
			end
		end
		out_ready <= (hold_left == 0) && !(hold_go && !hold_done) &&
			($urandom_range(99) >= rx_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic stat_op_t rand_item();
		stat_op_t it;
		int unsigned pick, h;
		pick = $urandom_range(99);
		h = $urandom_range(7);
		it = '{OP_ACC, hot_link[h], hot_chip[h], hot_chan[h], '0};
		if (pick < 70) begin
			// mostly near the channel pedestal, sometimes anywhere
			if ($urandom_range(3) == 0) it.smp = SMP_W'($urandom);
			else it.smp = hot_ped[h] + SMP_W'($urandom_range(16)) - SMP_W'(8);
		end else if (pick < 85) begin
			it.op = OP_READ;
		end else if (pick < 97) begin
			it = '{OP_ACC, LINK_W'($urandom), CHIP_W'($urandom), CHAN_W'($urandom),
				SMP_W'($urandom)};
			if ($urandom_range(1)) it.op = OP_READ;
		end else if (pick < 99) begin
			it = '{OP_UNUSED, LINK_W'($urandom), CHIP_W'($urandom), CHAN_W'($urandom),
				SMP_W'($urandom)};
		end else begin
			it.op = OP_READ;
			it.smp = SMP_W'($urandom);
		end
		return it;
	endfunction

	task automatic drain_ops();
		while (pending_ops.size() != 0 || in_valid) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			hot_link[i] = LINK_W'($urandom);
			hot_chip[i] = CHIP_W'($urandom);
			hot_chan[i] = CHAN_W'($urandom);
			hot_ped[i] = SMP_W'($urandom_range(1000, 16));
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every operation, unused code, clear
		pending_ops.push_back('{OP_READ, '0, '0, '0, '0});
		pending_ops.push_back('{OP_ACC, '0, '0, '0, '0});
		pending_ops.push_back('{OP_ACC, '0, '0, '0, '1});
		pending_ops.push_back('{OP_ACC, '0, '0, '0, '0});
		pending_ops.push_back('{OP_ACC, '0, '0, '0, '1});
		pending_ops.push_back('{OP_READ, '0, '0, '0, '1});
		pending_ops.push_back('{OP_ACC, '1, '1, '1, '1});
		pending_ops.push_back('{OP_ACC, '1, '1, '1, '1});
		pending_ops.push_back('{OP_ACC, '1, '1, '1, 10'd512});
		pending_ops.push_back('{OP_ACC, '1, '1, '1, 10'd1});
		pending_ops.push_back('{OP_READ, '1, '1, '1, '0});
		pending_ops.push_back('{OP_UNUSED, '1, '1, '1, '1});
		pending_ops.push_back('{OP_UNUSED, '0, '0, '0, '0});
		pending_ops.push_back('{OP_READ, 4'd5, 6'd42, 6'd21, '0});
		pending_ops.push_back('{OP_CLEAR, '1, '1, '1, '1});
		pending_ops.push_back('{OP_READ, '1, '1, '1, '0});
		pending_ops.push_back('{OP_READ, '0, '0, '0, '0});
		pending_ops.push_back('{OP_ACC, '0, '0, '0, 10'd700});
		pending_ops.push_back('{OP_READ, '0, '0, '0, '0});
		drain_ops();

		// random part: three idling phases, a clear mid-way
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 50 : 0;
			rx_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 23 : 0;
			for (int i = 0; i < 150; i++) pending_ops.push_back(rand_item());
			if (ph == 1) pending_ops.push_back('{OP_CLEAR, '0, '0, '0, '0});
			if (ph == 2) hold_go <= 1'b1;
			drain_ops();
		end

		while (expected_stats.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/pcrmv_pkg.sv
hw/rtl/pcrmv_div.sv
hw/rtl/per_channel_running_mean_variance.sv
tb/per_channel_running_mean_variance_tb.sv
